>>> src/iso286_pkg.sv
// Shared types, constants and tables for the ISO 286 limits-and-fits block.
// Holds the size bands, the IT tolerance table and the fundamental deviations.
// No dependencies.
package iso286_pkg;

  localparam int NOM_W  = 20;
  localparam int LET_W  = 4;
  localparam int GRD_W  = 7;
  localparam int BAND_W = 4;
  localparam int COL_W  = 3;
  localparam int IT_W   = 9;
  localparam int FUND_W = 8;
  localparam int DEV_W  = 12;
  localparam int CLR_W  = 13;

  localparam int NUM_TOPS  = 9;
  localparam int NUM_BANDS = 10;
  localparam int NUM_COLS  = 8;

  localparam logic [NOM_W-1:0] NOM_MIN = NOM_W'(200);
  localparam logic [GRD_W-1:0] GRADE_LO = GRD_W'(5);
  localparam logic [GRD_W-1:0] GRADE_HI = GRD_W'(12);
  // IT7 sits in column 2 of the tolerance table.
  localparam logic [COL_W-1:0] COL_DEFAULT = COL_W'(2);

  typedef enum logic [LET_W-1:0] {
    LET_H     = 4'd0,
    LET_G     = 4'd1,
    LET_F     = 4'd2,
    LET_K     = 4'd3,
    LET_N     = 4'd4,
    LET_P     = 4'd5,
    LET_S     = 4'd6,
    LET_J     = 4'd7,
    LET_OTHER = 4'd8
  } letter_t;

  typedef enum logic [1:0] {
    FIT_CLEARANCE    = 2'd0,
    FIT_TRANSITION   = 2'd1,
    FIT_INTERFERENCE = 2'd2
  } fit_kind_t;

  localparam logic [NOM_W-1:0] BAND_TOP [NUM_TOPS] = '{
    20'd3000, 20'd6000, 20'd10000, 20'd18000, 20'd30000,
    20'd50000, 20'd80000, 20'd120000, 20'd180000
  };

  localparam logic [IT_W-1:0] IT_TABLE [NUM_BANDS][NUM_COLS] = '{
    '{9'd4,  9'd6,  9'd10, 9'd14, 9'd25,  9'd40,  9'd60,  9'd100},
    '{9'd5,  9'd8,  9'd12, 9'd18, 9'd30,  9'd48,  9'd75,  9'd120},
    '{9'd6,  9'd9,  9'd15, 9'd22, 9'd36,  9'd58,  9'd90,  9'd150},
    '{9'd8,  9'd11, 9'd18, 9'd27, 9'd43,  9'd70,  9'd110, 9'd180},
    '{9'd9,  9'd13, 9'd21, 9'd33, 9'd52,  9'd84,  9'd130, 9'd210},
    '{9'd11, 9'd16, 9'd25, 9'd39, 9'd62,  9'd100, 9'd160, 9'd250},
    '{9'd13, 9'd19, 9'd30, 9'd46, 9'd74,  9'd120, 9'd190, 9'd300},
    '{9'd15, 9'd22, 9'd35, 9'd54, 9'd87,  9'd140, 9'd220, 9'd350},
    '{9'd18, 9'd25, 9'd40, 9'd63, 9'd100, 9'd160, 9'd250, 9'd400},
    '{9'd20, 9'd29, 9'd46, 9'd72, 9'd115, 9'd185, 9'd290, 9'd460}
  };

  localparam logic signed [FUND_W-1:0] DEV_G [NUM_BANDS] = '{
    -8'sd2, -8'sd4, -8'sd5, -8'sd6, -8'sd7, -8'sd9, -8'sd10, -8'sd12, -8'sd14, -8'sd15
  };
  localparam logic signed [FUND_W-1:0] DEV_F [NUM_BANDS] = '{
    -8'sd6, -8'sd10, -8'sd13, -8'sd16, -8'sd20, -8'sd25, -8'sd30, -8'sd36, -8'sd43, -8'sd50
  };
  localparam logic signed [FUND_W-1:0] DEV_K [NUM_BANDS] = '{
    8'sd0, 8'sd1, 8'sd1, 8'sd1, 8'sd2, 8'sd2, 8'sd2, 8'sd3, 8'sd3, 8'sd4
  };
  localparam logic signed [FUND_W-1:0] DEV_N [NUM_BANDS] = '{
    8'sd4, 8'sd8, 8'sd10, 8'sd12, 8'sd15, 8'sd17, 8'sd20, 8'sd23, 8'sd27, 8'sd31
  };
  localparam logic signed [FUND_W-1:0] DEV_P [NUM_BANDS] = '{
    8'sd6, 8'sd12, 8'sd15, 8'sd18, 8'sd22, 8'sd26, 8'sd32, 8'sd37, 8'sd43, 8'sd50
  };
  localparam logic signed [FUND_W-1:0] DEV_S [NUM_BANDS] = '{
    8'sd14, 8'sd19, 8'sd23, 8'sd28, 8'sd35, 8'sd43, 8'sd53, 8'sd66, 8'sd79, 8'sd92
  };

  // Decoded fit code after the first stage.
  typedef struct packed {
    logic [LET_W-1:0] letter;
    logic [COL_W-1:0] col;
    logic             lc;
  } fit_code_t;

  typedef struct packed {
    logic                     ok;
    logic [BAND_W-1:0]        band;
    fit_code_t                hole;
    fit_code_t                shaft;
  } stage1_t;

  // Table values for one fit code, in micrometres.
  typedef struct packed {
    logic [LET_W-1:0]         letter;
    logic                     lc;
    logic [IT_W-1:0]          it;
    logic signed [FUND_W-1:0] fund;
  } fit_lut_t;

  typedef struct packed {
    logic     ok;
    fit_lut_t hole;
    fit_lut_t shaft;
  } stage2_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] up;
    logic signed [DEV_W-1:0] lo;
  } dev_pair_t;

  typedef struct packed {
    dev_pair_t hole;
    dev_pair_t shaft;
  } stage3_t;

  // Band index is the number of band tops the nominal size exceeds.
  function automatic logic [BAND_W-1:0] band_of(input logic [NOM_W-1:0] um);
    logic [BAND_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < NUM_TOPS; i++) begin
      if (um > BAND_TOP[i]) cnt = cnt + BAND_W'(1);
    end
    return cnt;
  endfunction

  function automatic logic [COL_W-1:0] col_of(input logic [GRD_W-1:0] grade);
    logic [GRD_W-1:0] diff;
    diff = grade - GRADE_LO;
    if (grade >= GRADE_LO && grade <= GRADE_HI) return diff[COL_W-1:0];
    return COL_DEFAULT;
  endfunction

  function automatic logic signed [FUND_W-1:0] fund_of(input logic [LET_W-1:0] letter,
                                                       input logic [BAND_W-1:0] band);
    case (letter)
      LET_G:   return DEV_G[band];
      LET_F:   return DEV_F[band];
      LET_K:   return DEV_K[band];
      LET_N:   return DEV_N[band];
      LET_P:   return DEV_P[band];
      LET_S:   return DEV_S[band];
      default: return '0;
    endcase
  endfunction

  // Upper and lower deviations in half micrometres.
  function automatic dev_pair_t devs_of(input fit_lut_t f);
    dev_pair_t               r;
    logic signed [DEV_W-1:0] it1;
    logic signed [DEV_W-1:0] it2;
    logic signed [DEV_W-1:0] fund2;
    it1   = $signed({{(DEV_W-IT_W){1'b0}}, f.it});
    it2   = $signed({{(DEV_W-IT_W-1){1'b0}}, f.it, 1'b0});
    fund2 = $signed({{(DEV_W-FUND_W-1){f.fund[FUND_W-1]}}, f.fund, 1'b0});
    if (f.letter == LET_J) begin
      r.lo = -it1;
      r.up = it1;
    end else if (!f.lc) begin
      // Taken as a hole: only G is shifted, by the size of the g deviation.
      r.lo = (f.letter == LET_G) ? -fund2 : '0;
      r.up = r.lo + it2;
    end else if (f.letter == LET_H || f.letter == LET_G || f.letter == LET_F) begin
      r.up = fund2;
      r.lo = r.up - it2;
    end else begin
      r.lo = fund2;
      r.up = r.lo + it2;
    end
    return r;
  endfunction

endpackage

>>> src/iso286_fit_limits_and_class.sv
// Top level of the ISO 286 limits-and-fits evaluator: a four-stage pipeline.
// Depends on iso286_pkg for tables, types and helper functions.
//
// Usage:
//   A request on the s_ group carries a nominal size and two parsed fit codes;
//   the m_ group returns one result per request, in order. Both groups use the
//   tvalid/tready handshake.
//   Pipeline: decode (band, grade column, validity), table lookup, deviation
//   forming, then clearances and fit class into the output register.
//   The accepting edge loads the first stage; the request then moves through the
//   lookup, deviation and output registers, and m_tvalid rises with the last.
//   Throughput is one request per cycle while m_tready stays high, since every
//   stage can move on in the same cycle that its successor does.
//   Each stage advances on its own when it is empty or its successor takes
//   its content, so bubbles close up and a stalled receiver fills the pipe
//   before s_tready drops; nothing is lost or repeated while stalled.
//   An invalid request (nominal below 200 um or a non-letter code) returns
//   ok low with every other field zero.
//   Reset clears all stage valid bits; payload registers are not reset.
module iso286_fit_limits_and_class (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // nominal_um[19:0], hole_letter[23:20], hole_grade[30:24],
  // shaft_letter[34:31], shaft_grade[41:35], zero fill [47:42]
  input  logic [47:0] s_tdata,
  // hole_lowercase[0], shaft_lowercase[1]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hole_upper_dev[11:0], hole_lower_dev[23:12], shaft_upper_dev[35:24],
  // shaft_lower_dev[47:36], min_clearance[60:48], max_clearance[73:61],
  // zero fill [79:74]
  output logic [79:0] m_tdata,
  // ok[0], fit_kind[2:1]
  output logic [2:0]  m_tuser
);
  import iso286_pkg::*;

  logic [NOM_W-1:0] nominal_um;
  logic [LET_W-1:0] hole_letter;
  logic [GRD_W-1:0] hole_grade;
  logic [LET_W-1:0] shaft_letter;
  logic [GRD_W-1:0] shaft_grade;

  logic    v1, v2, v3, v4;
  logic    rdy1, rdy2, rdy3, rdy4;
  stage1_t st1, st1_next;
  stage2_t st2, st2_next;
  stage3_t st3, st3_next;
  logic    ok3;

  logic signed [DEV_W-1:0] hu, hl, su, sl;
  logic signed [CLR_W-1:0] cmin, cmax;
  logic signed [CLR_W-1:0] cmin_next, cmax_next;
  fit_kind_t               kind, kind_next;
  logic                    ok4;

  assign nominal_um   = s_tdata[19:0];
  assign hole_letter  = s_tdata[23:20];
  assign hole_grade   = s_tdata[30:24];
  assign shaft_letter = s_tdata[34:31];
  assign shaft_grade  = s_tdata[41:35];

  // Each stage can load when it is empty or its content moves on.
  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // Stage 1: size band, grade column and validity.
  always_comb begin
    st1_next.ok = (nominal_um >= NOM_MIN) &&
                  (hole_letter <= LET_OTHER) && (shaft_letter <= LET_OTHER);
    st1_next.band         = band_of(nominal_um);
    st1_next.hole.letter  = hole_letter;
    st1_next.hole.col     = col_of(hole_grade);
    st1_next.hole.lc      = s_tuser[0];
    st1_next.shaft.letter = shaft_letter;
    st1_next.shaft.col    = col_of(shaft_grade);
    st1_next.shaft.lc     = s_tuser[1];
  end

  // Stage 2: IT tolerance and fundamental deviation lookups.
  always_comb begin
    st2_next.ok           = st1.ok;
    st2_next.hole.letter  = st1.hole.letter;
    st2_next.hole.lc      = st1.hole.lc;
    st2_next.hole.it      = IT_TABLE[st1.band][st1.hole.col];
    st2_next.hole.fund    = fund_of(st1.hole.letter, st1.band);
    st2_next.shaft.letter = st1.shaft.letter;
    st2_next.shaft.lc     = st1.shaft.lc;
    st2_next.shaft.it     = IT_TABLE[st1.band][st1.shaft.col];
    st2_next.shaft.fund   = fund_of(st1.shaft.letter, st1.band);
  end

  // Stage 3: deviations, forced to zero for an invalid request.
  always_comb begin
    st3_next.hole  = devs_of(st2.hole);
    st3_next.shaft = devs_of(st2.shaft);
    if (!st2.ok) begin
      st3_next = '0;
    end
  end

  // Stage 4: clearances and fit class.
  always_comb begin
    cmin_next = CLR_W'(st3.hole.lo) - CLR_W'(st3.shaft.up);
    cmax_next = CLR_W'(st3.hole.up) - CLR_W'(st3.shaft.lo);
    if (!cmin_next[CLR_W-1]) begin
      kind_next = FIT_CLEARANCE;
    end else if (cmax_next[CLR_W-1] || cmax_next == '0) begin
      kind_next = FIT_INTERFERENCE;
    end else begin
      kind_next = FIT_TRANSITION;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) st1 <= st1_next;
    if (rdy2) st2 <= st2_next;
    if (rdy3) begin
      st3 <= st3_next;
      ok3 <= st2.ok;
    end
    if (rdy4) begin
      hu   <= st3.hole.up;
      hl   <= st3.hole.lo;
      su   <= st3.shaft.up;
      sl   <= st3.shaft.lo;
      cmin <= cmin_next;
      cmax <= cmax_next;
      kind <= kind_next;
      ok4  <= ok3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {6'b0, cmax, cmin, sl, su, hl, hu};
  assign m_tuser  = {kind, ok4};

  // An invalid request must come out with every numeric field zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !ok4) |-> (m_tdata == '0 && kind == FIT_CLEARANCE))
    else $error("invalid request produced nonzero result");

  // Every valid fit has its upper deviation strictly above its lower one.
  a_dev_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ok4) |-> (hu > hl && su > sl))
    else $error("deviation order broken");

  // The class must agree with the sign of the minimum clearance.
  a_kind_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((kind == FIT_CLEARANCE) == !cmin[CLR_W-1]))
    else $error("fit class disagrees with minimum clearance");

  // The input side can only be held off when a result is waiting.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with output free");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Testbench for iso286_fit_limits_and_class: directed and random fit queries through the
// stream ports, checked against an in-bench model of the ISO 286 deviation tables.
// Depends on iso286_pkg for the letter and fit-class enums and the field widths.
module tb;
  import iso286_pkg::*;

  localparam logic [LET_W-1:0] NOT_A_LETTER = 4'd9;
  localparam logic [LET_W-1:0] UNUSED_CODE  = 4'd15;

  localparam int NOM_FLOOR = 200;
  localparam int BAND_TOP_UM [9] = '{3000, 6000, 10000, 18000, 30000,
                                     50000, 80000, 120000, 180000};
  localparam int TOL_UM [10][8] = '{
    '{4, 6, 10, 14, 25, 40, 60, 100},    '{5, 8, 12, 18, 30, 48, 75, 120},
    '{6, 9, 15, 22, 36, 58, 90, 150},    '{8, 11, 18, 27, 43, 70, 110, 180},
    '{9, 13, 21, 33, 52, 84, 130, 210},  '{11, 16, 25, 39, 62, 100, 160, 250},
    '{13, 19, 30, 46, 74, 120, 190, 300}, '{15, 22, 35, 54, 87, 140, 220, 350},
    '{18, 25, 40, 63, 100, 160, 250, 400}, '{20, 29, 46, 72, 115, 185, 290, 460}
  };
  localparam int G_UM [10] = '{-2, -4, -5, -6, -7, -9, -10, -12, -14, -15};
  localparam int F_UM [10] = '{-6, -10, -13, -16, -20, -25, -30, -36, -43, -50};
  localparam int K_UM [10] = '{0, 1, 1, 1, 2, 2, 2, 3, 3, 4};
  localparam int N_UM [10] = '{4, 8, 10, 12, 15, 17, 20, 23, 27, 31};
  localparam int P_UM [10] = '{6, 12, 15, 18, 22, 26, 32, 37, 43, 50};
  localparam int S_UM [10] = '{14, 19, 23, 28, 35, 43, 53, 66, 79, 92};

  typedef struct packed {
    logic [NOM_W-1:0] nominal;
    logic [LET_W-1:0] hole_letter;
    logic [GRD_W-1:0] hole_grade;
    logic             hole_lc;
    logic [LET_W-1:0] shaft_letter;
    logic [GRD_W-1:0] shaft_grade;
    logic             shaft_lc;
  } fit_query_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DEV_W-1:0] hole_up;
    logic signed [DEV_W-1:0] hole_lo;
    logic signed [DEV_W-1:0] shaft_up;
    logic signed [DEV_W-1:0] shaft_lo;
    logic signed [CLR_W-1:0] min_clr;
    logic signed [CLR_W-1:0] max_clr;
    fit_kind_t               kind;
  } fit_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;

  fit_result_t expected_fits[$];
  int          n_fit_errors = 0;
  bit          idle_bursts = 1'b1;

  iso286_fit_limits_and_class i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Number of band tops the size exceeds; sizes above 180 mm share the top band.
  function automatic int band_index(input logic [NOM_W-1:0] um);
    int b;
    b = 0;
    while (b < 9 && int'(um) > BAND_TOP_UM[b]) b++;
    return b;
  endfunction

  function automatic int fund_dev_um(input logic [LET_W-1:0] letter, input int band);
    case (letter)
      LET_G:   return G_UM[band];
      LET_F:   return F_UM[band];
      LET_K:   return K_UM[band];
      LET_N:   return N_UM[band];
      LET_P:   return P_UM[band];
      LET_S:   return S_UM[band];
      default: return 0;
    endcase
  endfunction

  // Upper and lower deviation of one fit code, in half micrometres.
  function automatic void fit_limits(input logic [LET_W-1:0] letter,
                                     input logic [GRD_W-1:0] grade,
                                     input logic lc, input int band,
                                     output int up, output int lo);
    int col;
    int tol;
    col = (grade >= 5 && grade <= 12) ? int'(grade) - 5 : 2;
    tol = TOL_UM[band][col];
    if (letter == LET_J) begin
      lo = -tol;
      up = tol;
    end else if (!lc) begin
      lo = (letter == LET_G) ? -2 * G_UM[band] : 0;
      up = lo + 2 * tol;
    end else if (letter == LET_H || letter == LET_G || letter == LET_F) begin
      up = 2 * fund_dev_um(letter, band);
      lo = up - 2 * tol;
    end else begin
      lo = 2 * fund_dev_um(letter, band);
      up = lo + 2 * tol;
    end
  endfunction

  function automatic fit_result_t predict_fit(input fit_query_t q);
    fit_result_t r;
    int band, hu, hl, su, sl, cmin, cmax;
    r = '0;
    if (q.nominal < NOM_FLOOR || q.hole_letter > LET_OTHER || q.shaft_letter > LET_OTHER)
      return r;
    band = band_index(q.nominal);
    fit_limits(q.hole_letter, q.hole_grade, q.hole_lc, band, hu, hl);
    fit_limits(q.shaft_letter, q.shaft_grade, q.shaft_lc, band, su, sl);
    cmin = hl - su;
    cmax = hu - sl;
    r.ok       = 1'b1;
    r.hole_up  = DEV_W'(hu);
    r.hole_lo  = DEV_W'(hl);
    r.shaft_up = DEV_W'(su);
    r.shaft_lo = DEV_W'(sl);
    r.min_clr  = CLR_W'(cmin);
    r.max_clr  = CLR_W'(cmax);
    if (cmin >= 0) r.kind = FIT_CLEARANCE;
    else if (cmax <= 0) r.kind = FIT_INTERFERENCE;
    else r.kind = FIT_TRANSITION;
    return r;
  endfunction

  function automatic fit_query_t make_query(input int nom,
                                            input logic [LET_W-1:0] hl, input int hg, input bit hc,
                                            input logic [LET_W-1:0] sl, input int sg, input bit sc);
    fit_query_t q;
    q.nominal      = NOM_W'(nom);
    q.hole_letter  = hl;
    q.hole_grade   = GRD_W'(hg);
    q.hole_lc      = hc;
    q.shaft_letter = sl;
    q.shaft_grade  = GRD_W'(sg);
    q.shaft_lc     = sc;
    return q;
  endfunction

  function automatic logic [LET_W-1:0] random_letter();
    if ($urandom_range(0, 11) == 0) return LET_W'($urandom_range(0, 15));
    return LET_W'($urandom_range(0, 8));
  endfunction

  function automatic int random_grade();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 127);
    return $urandom_range(5, 12);
  endfunction

  function automatic fit_query_t random_query();
    int nom;
    int edge_pick;
    case ($urandom_range(0, 9))
      0: nom = $urandom_range(0, 20'hFFFFF);
      1: nom = $urandom_range(0, NOM_FLOOR - 1);
      2, 3: begin
        // Just around a band top or the minimum size.
        edge_pick = $urandom_range(0, 9);
        nom = (edge_pick == 9) ? NOM_FLOOR : BAND_TOP_UM[edge_pick];
        nom = nom + $urandom_range(0, 4) - 2;
      end
      default: nom = $urandom_range(NOM_FLOOR, 250000);
    endcase
    return make_query(nom, random_letter(), random_grade(), $urandom_range(0, 4) == 0,
                      random_letter(), random_grade(), $urandom_range(0, 4) != 0);
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic send_query(input fit_query_t q);
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, q.shaft_grade, q.shaft_letter, q.hole_grade, q.hole_letter, q.nominal};
    s_tuser  <= {q.shaft_lc, q.hole_lc};
    do @(posedge clk); while (!s_tready);
    expected_fits = {expected_fits, predict_fit(q)};
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    n_fit_errors++;
    if (n_fit_errors <= 10)
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic compare_fit(input fit_result_t want, input fit_result_t got);
    if (got.ok !== want.ok) flag_mismatch("ok", want.ok, got.ok);
    if (got.hole_up !== want.hole_up) flag_mismatch("hole_upper_dev", want.hole_up, got.hole_up);
    if (got.hole_lo !== want.hole_lo) flag_mismatch("hole_lower_dev", want.hole_lo, got.hole_lo);
    if (got.shaft_up !== want.shaft_up)
      flag_mismatch("shaft_upper_dev", want.shaft_up, got.shaft_up);
    if (got.shaft_lo !== want.shaft_lo)
      flag_mismatch("shaft_lower_dev", want.shaft_lo, got.shaft_lo);
    if (got.min_clr !== want.min_clr) flag_mismatch("min_clearance", want.min_clr, got.min_clr);
    if (got.max_clr !== want.max_clr) flag_mismatch("max_clearance", want.max_clr, got.max_clr);
    if (got.kind !== want.kind) flag_mismatch("fit_kind", int'(want.kind), int'(got.kind));
  endtask

  // Receiver: random stall bursts on m_tready, and a check of every result taken.
  always @(posedge clk) begin
    int stall_left;
    fit_result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.ok       = m_tuser[0];
        got.kind     = fit_kind_t'(m_tuser[2:1]);
        got.hole_up  = m_tdata[11:0];
        got.hole_lo  = m_tdata[23:12];
        got.shaft_up = m_tdata[35:24];
        got.shaft_lo = m_tdata[47:36];
        got.min_clr  = m_tdata[60:48];
        got.max_clr  = m_tdata[73:61];
        if (expected_fits.size() == 0) flag_mismatch("result with no request pending, ok", 0,
                                                     got.ok);
        else compare_fit(expected_fits.pop_front(), got);
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= (stall_left == 0);
      end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic test_invalid_inputs();
    send_query(make_query(0, LET_H, 7, 0, LET_G, 6, 1));
    send_query(make_query(NOM_FLOOR - 1, LET_H, 7, 0, LET_H, 7, 1));
    send_query(make_query(NOM_FLOOR, LET_H, 7, 0, LET_G, 6, 1));
    send_query(make_query(20'hFFFFF, NOT_A_LETTER, 7, 0, LET_H, 6, 1));
    send_query(make_query(25000, LET_H, 7, 0, UNUSED_CODE, 6, 1));
  endtask

  task automatic test_band_edges();
    send_query(make_query(3000, LET_H, 7, 0, LET_F, 7, 1));
    send_query(make_query(3001, LET_G, 7, 0, LET_H, 6, 1));
    send_query(make_query(180000, LET_J, 12, 0, LET_J, 5, 1));
    send_query(make_query(180001, LET_P, 7, 0, LET_S, 6, 1));
    send_query(make_query(20'hFFFFF, LET_H, 12, 0, LET_S, 12, 1));
  endtask

  task automatic test_letters_and_grades();
    send_query(make_query(10000, LET_G, 5, 0, LET_G, 5, 1));
    send_query(make_query(18000, LET_F, 8, 0, LET_F, 8, 1));
    send_query(make_query(30000, LET_K, 9, 0, LET_K, 9, 1));
    send_query(make_query(50000, LET_N, 10, 0, LET_N, 10, 1));
    send_query(make_query(80000, LET_P, 11, 0, LET_P, 11, 1));
    send_query(make_query(120000, LET_S, 12, 0, LET_S, 12, 1));
    // Grades just outside 5..12 and at the field extremes fall back to IT7.
    send_query(make_query(6000, LET_J, 4, 0, LET_J, 13, 1));
    send_query(make_query(45000, LET_OTHER, 0, 0, LET_OTHER, 127, 1));
    // A lowercase first code with an uppercase second code swaps roles; the last two give both the same case.
    send_query(make_query(700, LET_H, 7, 1, LET_G, 6, 0));
    send_query(make_query(2500, LET_G, 6, 1, LET_K, 6, 0));
    send_query(make_query(150000, LET_F, 7, 1, LET_S, 7, 1));
    send_query(make_query(90000, LET_N, 6, 0, LET_OTHER, 6, 0));
  endtask

  task automatic test_random_fits(input int count);
    for (int i = 0; i < count; i++) send_query(random_query());
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 30; i++) send_query(random_query());
    wait_until_drained();
    for (int i = 0; i < 30; i++) send_query(random_query());
  endtask

  task automatic test_back_to_back(input int count);
    idle_bursts = 1'b0;
    for (int i = 0; i < count; i++) send_query(random_query());
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_invalid_inputs();
    test_band_edges();
    test_letters_and_grades();
    test_random_fits(1300);
    test_sender_pause();
    test_back_to_back(480);
    wait_until_drained();
    repeat (8) @(posedge clk);
    if (n_fit_errors == 0 && expected_fits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
src/iso286_pkg.sv
src/iso286_fit_limits_and_class.sv
bench/tb.sv
